/* hdl/sps_pkg.sv */
// Package for the S-curve profile step engine: item, configuration and
// control types, segment and action codes, and sizing constants.
// No dependencies; every other file of the block refers to it.
`default_nettype none

package sps_pkg;

  localparam int DivW = 24;
  localparam int DivCntW = $clog2(DivW);
  localparam logic [DivCntW-1:0] DivLast = DivCntW'(DivW - 1);
  localparam logic [30:0] DistMax = 31'h7FFF_FFFF;
  localparam logic [23:0] StopSpeed = 24'd2;
  localparam logic [23:0] VelMax = 24'hFF_FFFF;

  localparam logic [2:0] SEG_DONE           = 3'd0;
  localparam logic [2:0] SEG_JERK_UP        = 3'd1;
  localparam logic [2:0] SEG_CONST_ACC      = 3'd2;
  localparam logic [2:0] SEG_JERK_DOWN      = 3'd3;
  localparam logic [2:0] SEG_CRUISE         = 3'd4;
  localparam logic [2:0] SEG_DEC_JERK_UP    = 3'd5;
  localparam logic [2:0] SEG_DEC_CONST      = 3'd6;
  localparam logic [2:0] SEG_DEC_JERK_DOWN  = 3'd7;

  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_START = 2'd1,
    ACT_STOP  = 2'd2
  } action_e;

  typedef enum logic [2:0] {
    CFG_MAX_SPEED    = 3'd0,
    CFG_MAX_ACCEL    = 3'd1,
    CFG_JERK_STEP    = 3'd2,
    CFG_JERK_TICKS   = 3'd3,
    CFG_CONST_TICKS  = 3'd4,
    CFG_CRUISE_EN    = 3'd5,
    CFG_BRAKE_DIST   = 3'd6,
    CFG_GOAL_POS     = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic        [1:0]  action;
    logic signed [31:0] start_position;
  } in_t;

  typedef struct packed {
    logic signed [31:0] position;
    logic        [23:0] speed;
    logic        [2:0]  segment;
    logic               done_res;
  } out_t;

  typedef struct packed {
    logic [23:0] max_speed;
    logic [23:0] max_accel;
    logic [23:0] jerk_step;
    logic [23:0] jerk_ticks;
    logic [23:0] const_accel_ticks;
    logic        cruise_enable;
    logic [30:0] brake_distance;
    logic [31:0] goal_position;
  } cfg_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LATCH,
    OP_TICK_ACC,
    OP_TICK_VEL,
    OP_TICK_POS,
    OP_TICK_SNAP,
    OP_START,
    OP_STOP_ZERO,
    OP_DIV_TJ_GO,
    OP_DIV_TJ_WAIT,
    OP_L1_INIT,
    OP_L1_STEP,
    OP_DIV_TD_GO,
    OP_DIV_TD_WAIT,
    OP_DIV_M_GO,
    OP_DIV_M_WAIT,
    OP_MUL_P1,
    OP_MUL_P2,
    OP_MUL_P3,
    OP_MID_SUM,
    OP_L2_INIT,
    OP_L2_STEP,
    OP_TAIL_MUL,
    OP_TAIL_ADD,
    OP_STOP_END
  } op_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_TICK_ACC,
    S_TICK_VEL,
    S_TICK_POS,
    S_TICK_SNAP,
    S_START,
    S_STOP_CHK,
    S_DTJ_GO,
    S_DTJ_WAIT,
    S_L1_INIT,
    S_L1,
    S_DTD_GO,
    S_DTD_WAIT,
    S_DM_GO,
    S_DM_WAIT,
    S_MUL1,
    S_MUL2,
    S_MUL3,
    S_MID,
    S_L2_INIT,
    S_L2,
    S_TAIL_MUL,
    S_TAIL_ADD,
    S_STOP_END,
    S_OUT
  } state_e;

  typedef struct packed {
    op_e  op;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic seg_done;
    logic stop_skip;
    logic stop_trivial;
    logic div_done;
    logic div_quo_zero;
    logic run_done;
    logic tail;
  } dp_status_t;

endpackage

`default_nettype wire

/* hdl/scurve_profile_step_engine.sv */
// Top level of the S-curve profile step engine: configuration registers,
// result register and the controller/datapath pair. Depends on sps_pkg,
// sps_ctrl, sps_dp and sps_div.
`default_nettype none

// The engine takes one item at a time: a tick, a start or a smooth stop, and
// returns exactly one result item per input item with the position, speed
// and segment after it. A tick runs four datapath steps that integrate
// acceleration, velocity and position and then test for the near-target snap,
// and then loads the result register; a start sets up the move and then loads
// the result register, a tick while done or an unused action code goes straight
// to the result load, and a stop that is ignored or that finishes at once
// passes through the controller's check of the segment and speed first. A
// smooth stop runs the deceleration simulation in the controller's sequence:
// two or three divisions on the shared radix-2 divider (the third only when
// a constant-deceleration span is left), two passes over the jerk time
// (jerk time = max_accel / jerk_step, at least one), and a handful of
// multiply and add steps.
// The input is taken again as soon as the result of the previous item is
// registered, even while that result still waits on a stalled output.
// Configuration writes are always accepted and should only be made while
// the engine is idle.

module scurve_profile_step_engine (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  input  wire sps_pkg::in_t    in_item_i,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output sps_pkg::out_t        out_item_o,
  input  wire logic            cfg_valid_i,
  output logic                 cfg_ready_o,
  input  wire logic [2:0]      cfg_index_i,
  input  wire logic [31:0]     cfg_data_i
);

  sps_pkg::cfg_t       cfg_q;
  sps_pkg::cmd_t       cmd;
  sps_pkg::dp_status_t status;
  sps_pkg::out_t       result, out_q;
  logic                out_valid_q, out_free;

  assign cfg_ready_o = 1'b1;

  // Configuration registers, reset to the values of an inert profile.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_speed         <= 24'd1;
      cfg_q.max_accel         <= 24'd1;
      cfg_q.jerk_step         <= 24'd1;
      cfg_q.jerk_ticks        <= 24'd1;
      cfg_q.const_accel_ticks <= '0;
      cfg_q.cruise_enable     <= 1'b0;
      cfg_q.brake_distance    <= '0;
      cfg_q.goal_position     <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (sps_pkg::cfg_idx_e'(cfg_index_i))
        sps_pkg::CFG_MAX_SPEED:   cfg_q.max_speed         <= cfg_data_i[23:0];
        sps_pkg::CFG_MAX_ACCEL:   cfg_q.max_accel         <= cfg_data_i[23:0];
        sps_pkg::CFG_JERK_STEP:   cfg_q.jerk_step         <= cfg_data_i[23:0];
        sps_pkg::CFG_JERK_TICKS:  cfg_q.jerk_ticks        <= cfg_data_i[23:0];
        sps_pkg::CFG_CONST_TICKS: cfg_q.const_accel_ticks <= cfg_data_i[23:0];
        sps_pkg::CFG_CRUISE_EN:   cfg_q.cruise_enable     <= cfg_data_i[0];
        sps_pkg::CFG_BRAKE_DIST:  cfg_q.brake_distance    <= cfg_data_i[30:0];
        sps_pkg::CFG_GOAL_POS:    cfg_q.goal_position     <= cfg_data_i;
        default:                  cfg_q.goal_position     <= cfg_q.goal_position;
      endcase
    end
  end

  // The result register frees up in the same cycle that its item is taken.
  assign out_free = !out_valid_q || !out_stall_i;

  sps_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .action_i   (in_item_i.action),
    .out_free_i (out_free),
    .status_i   (status),
    .cmd_o      (cmd),
    .in_stall_o (in_stall_o)
  );

  sps_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .op_i        (cmd.op),
    .start_pos_i (in_item_i.start_position),
    .status_o    (status),
    .result_o    (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd.load_out) out_q <= result;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // Every accepted item sends the controller out of its idle state.
  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not stalled after an item was accepted");

  // A result is only loaded into a free register and then shows as valid.
  a_load_shows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |=> out_valid_o)
    else $error("loaded result not presented");

  // The done flag and the segment code agree on every presented result.
  a_done_matches : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.done_res == (out_item_o.segment == sps_pkg::SEG_DONE)))
    else $error("done flag disagrees with segment");

endmodule

`default_nettype wire

/* hdl/sps_div.sv */
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on sps_pkg for the operand width.
`default_nettype none

module sps_div (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic [sps_pkg::DivW-1:0]  num_i,
  input  wire logic [sps_pkg::DivW-1:0]  den_i,
  output logic      [sps_pkg::DivW-1:0]  quo_o,
  output logic                           done_o
);

  logic [sps_pkg::DivW-1:0]    rem_q, quo_q, den_q;
  logic [sps_pkg::DivCntW-1:0] cnt_q;
  logic                        busy_q, done_q;
  logic [sps_pkg::DivW+1:0]    trial;
  logic                        ge;

  assign trial = {1'b0, rem_q, quo_q[sps_pkg::DivW-1]} - {2'b00, den_q};
  assign ge    = ~trial[sps_pkg::DivW+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      if (cnt_q == sps_pkg::DivLast) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
      cnt_q <= cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= num_i;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= ge ? trial[sps_pkg::DivW-1:0]
                  : {rem_q[sps_pkg::DivW-2:0], quo_q[sps_pkg::DivW-1]};
      quo_q <= {quo_q[sps_pkg::DivW-2:0], ge};
    end
  end

  assign quo_o  = quo_q;
  assign done_o = done_q;

endmodule

`default_nettype wire

/* hdl/sps_dp.sv */
// Datapath of the S-curve profile step engine: motion state, tick
// integration, start handling and the stop-distance simulation.
// Depends on sps_pkg and sps_div.
`default_nettype none

module sps_dp (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire sps_pkg::cfg_t       cfg_i,
  input  wire sps_pkg::op_e        op_i,
  input  wire logic signed [31:0]  start_pos_i,
  output sps_pkg::dp_status_t      status_o,
  output sps_pkg::out_t            result_o
);

  // Architectural motion state.
  logic [31:0]        pos_q, tgt_q;
  logic [23:0]        vel_q, el_q, djc_q, dcc_q;
  logic signed [24:0] acc_q;
  logic [2:0]         seg_q;
  logic               dir_q;
  logic [30:0]        stopd_q;

  // Scratch registers.
  logic [31:0]        spos_q;
  logic signed [33:0] remv_q;
  logic [23:0]        tj2_q, td_q, m_q, t_q, tailk_q, p1_q;
  logic signed [24:0] sa_q, sv_q;
  logic [30:0]        dist_q;
  logic [47:0]        ent_q, p3_q;
  logic [48:0]        p2_q;
  logic signed [24:0] term_q;
  logic               brk_q, run_q, tail_q;

  logic                     div_start;
  logic [sps_pkg::DivW-1:0] div_num, div_den, div_quo;
  logic                     div_done;

  function automatic logic [30:0] sat_add(input logic [30:0] d, input logic [47:0] x);
    logic [48:0] s;
    s = {18'b0, d} + {1'b0, x};
    return (s > {18'b0, sps_pkg::DistMax}) ? sps_pkg::DistMax : s[30:0];
  endfunction

  // Tick stage one: acceleration and cruise margin.
  logic signed [25:0] a_up, a_dn, mxa26, a1;
  logic [23:0]        el_inc;
  logic [31:0]        rem32;

  always_comb begin
    a_up  = $signed({acc_q[24], acc_q}) + $signed({2'b00, cfg_i.jerk_step});
    a_dn  = $signed({acc_q[24], acc_q}) - $signed({2'b00, cfg_i.jerk_step});
    mxa26 = $signed({2'b00, cfg_i.max_accel});
    unique case (seg_q)
      sps_pkg::SEG_JERK_UP:       a1 = (a_up > mxa26) ? mxa26 : a_up;
      sps_pkg::SEG_JERK_DOWN:     a1 = (a_dn < 26'sd0) ? 26'sd0 : a_dn;
      sps_pkg::SEG_CRUISE:        a1 = 26'sd0;
      sps_pkg::SEG_DEC_JERK_UP:   a1 = (a_dn < -mxa26) ? -mxa26 : a_dn;
      sps_pkg::SEG_DEC_JERK_DOWN: a1 = (a_up > 26'sd0) ? 26'sd0 : a_up;
      default:                    a1 = {acc_q[24], acc_q};
    endcase
    el_inc = (el_q == sps_pkg::VelMax) ? el_q : el_q + 24'd1;
    rem32  = dir_q ? (pos_q - tgt_q) : (tgt_q - pos_q);
  end

  // Tick stage two: velocity and segment transitions.
  logic signed [26:0] v27, acc27, mxv27, mxa27, vs, vp;
  logic [23:0]        vfin;
  logic [2:0]         seg_n;
  logic [23:0]        el_n;
  logic signed [24:0] acc_n;

  always_comb begin
    v27   = $signed({3'b000, vel_q});
    acc27 = $signed({{2{acc_q[24]}}, acc_q});
    mxv27 = $signed({3'b000, cfg_i.max_speed});
    mxa27 = $signed({3'b000, cfg_i.max_accel});
    vs    = v27 + acc27;
    vp    = v27;
    seg_n = seg_q;
    el_n  = el_q;
    acc_n = acc_q;
    unique case (seg_q)
      sps_pkg::SEG_JERK_UP: begin
        vp = (vs > mxv27) ? mxv27 : vs;
        if (el_q >= cfg_i.jerk_ticks) begin
          if (cfg_i.const_accel_ticks != 24'd0) seg_n = sps_pkg::SEG_CONST_ACC;
          else if (vp >= mxv27)                 seg_n = sps_pkg::SEG_CRUISE;
          else                                  seg_n = sps_pkg::SEG_JERK_DOWN;
          el_n = '0;
        end
      end
      sps_pkg::SEG_CONST_ACC: begin
        vp = ((v27 + mxa27) > mxv27) ? mxv27 : (v27 + mxa27);
        if (el_q >= cfg_i.const_accel_ticks) begin
          seg_n = sps_pkg::SEG_JERK_DOWN;
          el_n  = '0;
        end
      end
      sps_pkg::SEG_JERK_DOWN: begin
        vp = (vs > mxv27) ? mxv27 : vs;
        if (el_q >= cfg_i.jerk_ticks || acc_q <= 25'sd0) begin
          acc_n = '0;
          seg_n = cfg_i.cruise_enable ? sps_pkg::SEG_CRUISE : sps_pkg::SEG_DEC_JERK_UP;
          el_n  = '0;
        end
      end
      sps_pkg::SEG_CRUISE: begin
        acc_n = '0;
        if (remv_q <= $signed({3'b000, stopd_q})) begin
          seg_n = sps_pkg::SEG_DEC_JERK_UP;
          el_n  = '0;
        end
      end
      sps_pkg::SEG_DEC_JERK_UP: begin
        vp = (vs < 27'sd0) ? 27'sd0 : vs;
        if (el_q >= djc_q) begin
          seg_n = (dcc_q != 24'd0) ? sps_pkg::SEG_DEC_CONST : sps_pkg::SEG_DEC_JERK_DOWN;
          el_n  = '0;
        end
      end
      sps_pkg::SEG_DEC_CONST: begin
        vp = ((v27 - mxa27) < 27'sd0) ? 27'sd0 : (v27 - mxa27);
        if (el_q >= dcc_q) begin
          seg_n = sps_pkg::SEG_DEC_JERK_DOWN;
          el_n  = '0;
        end
      end
      sps_pkg::SEG_DEC_JERK_DOWN: begin
        vp = (vs < 27'sd0) ? 27'sd0 : vs;
        if (el_q >= djc_q || vp <= $signed({3'b000, cfg_i.jerk_step})) begin
          vp    = 27'sd0;
          acc_n = '0;
          seg_n = sps_pkg::SEG_DONE;
          el_n  = '0;
        end
      end
      default: vp = v27;
    endcase
    if (vp < 27'sd0)                                vfin = '0;
    else if (vp > $signed({3'b000, sps_pkg::VelMax})) vfin = sps_pkg::VelMax;
    else                                            vfin = vp[23:0];
  end

  // Position update, snap test and start.
  logic [31:0] pos_step, snap_d, start_diff;
  logic        snap;

  always_comb begin
    pos_step   = dir_q ? (pos_q - {8'b0, vel_q}) : (pos_q + {8'b0, vel_q});
    snap_d     = tgt_q - pos_q;
    snap       = (vel_q <= sps_pkg::StopSpeed) && (seg_q != sps_pkg::SEG_DONE) &&
                 ($signed(snap_d) <= 32'sd2) && ($signed(snap_d) >= -32'sd2);
    start_diff = cfg_i.goal_position - spos_q;
  end

  // Stop simulation steps.
  logic signed [25:0] negma, sa_m, sa1, sv1, sa_p, sa2, sv2;
  logic [23:0]        budget, m_sel;
  logic [47:0]        mid_add;

  always_comb begin
    negma   = -$signed({2'b00, cfg_i.max_accel});
    sa_m    = $signed({sa_q[24], sa_q}) - $signed({2'b00, cfg_i.jerk_step});
    sa1     = (sa_m < negma) ? negma : sa_m;
    sv1     = $signed({sv_q[24], sv_q}) + sa1;
    sa_p    = $signed({sa_q[24], sa_q}) + $signed({2'b00, cfg_i.jerk_step});
    sa2     = (sa_p > 26'sd0) ? 26'sd0 : sa_p;
    sv2     = $signed({sv_q[24], sv_q}) + sa2;
    budget  = ({24'b0, sv_q[23:0]} > ent_q) ? (sv_q[23:0] - ent_q[23:0]) : 24'd0;
    m_sel   = (div_quo > td_q) ? td_q : div_quo;
    mid_add = p3_q - p2_q[48:1];
  end

  always_comb begin
    div_start = 1'b0;
    div_num   = cfg_i.max_accel;
    div_den   = cfg_i.jerk_step;
    unique case (op_i)
      sps_pkg::OP_DIV_TJ_GO: div_start = 1'b1;
      sps_pkg::OP_DIV_TD_GO: begin
        div_start = 1'b1;
        div_num   = budget;
        div_den   = cfg_i.max_accel;
      end
      sps_pkg::OP_DIV_M_GO: begin
        div_start = 1'b1;
        div_num   = sv_q[23:0] - 24'd1;
        div_den   = cfg_i.max_accel;
      end
      default: div_start = 1'b0;
    endcase
  end

  sps_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .quo_o   (div_quo),
    .done_o  (div_done)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      vel_q   <= '0;
      acc_q   <= '0;
      seg_q   <= sps_pkg::SEG_DONE;
      el_q    <= '0;
      dir_q   <= 1'b0;
      tgt_q   <= '0;
      stopd_q <= '0;
      djc_q   <= '0;
      dcc_q   <= '0;
    end else begin
      unique case (op_i)
        sps_pkg::OP_TICK_ACC: begin
          acc_q <= a1[24:0];
          el_q  <= el_inc;
        end
        sps_pkg::OP_TICK_VEL: begin
          vel_q <= vfin;
          acc_q <= acc_n;
          seg_q <= seg_n;
          el_q  <= el_n;
        end
        sps_pkg::OP_TICK_POS: pos_q <= pos_step;
        sps_pkg::OP_TICK_SNAP: begin
          if (snap) begin
            pos_q <= tgt_q;
            vel_q <= '0;
            acc_q <= '0;
            seg_q <= sps_pkg::SEG_DONE;
          end
        end
        sps_pkg::OP_START: begin
          vel_q <= '0;
          acc_q <= '0;
          el_q  <= '0;
          tgt_q <= cfg_i.goal_position;
          if (start_diff == 32'd0) begin
            pos_q   <= cfg_i.goal_position;
            seg_q   <= sps_pkg::SEG_DONE;
            dir_q   <= 1'b0;
            stopd_q <= '0;
            djc_q   <= '0;
            dcc_q   <= '0;
          end else begin
            pos_q   <= spos_q;
            seg_q   <= sps_pkg::SEG_JERK_UP;
            dir_q   <= start_diff[31];
            stopd_q <= cfg_i.brake_distance;
            djc_q   <= cfg_i.jerk_ticks;
            dcc_q   <= cfg_i.const_accel_ticks;
          end
        end
        sps_pkg::OP_STOP_ZERO: begin
          seg_q <= sps_pkg::SEG_DONE;
          acc_q <= '0;
          vel_q <= '0;
        end
        sps_pkg::OP_STOP_END: begin
          stopd_q <= dist_q;
          tgt_q   <= dir_q ? (pos_q - {1'b0, dist_q}) : (pos_q + {1'b0, dist_q});
          djc_q   <= tj2_q;
          dcc_q   <= td_q;
          seg_q   <= sps_pkg::SEG_DEC_JERK_UP;
          el_q    <= '0;
          acc_q   <= '0;
        end
        default: seg_q <= seg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (op_i)
      sps_pkg::OP_LATCH:    spos_q <= start_pos_i;
      sps_pkg::OP_TICK_ACC: remv_q <= $signed({{2{rem32[31]}}, rem32}) -
                                      $signed({10'b0, vel_q});
      sps_pkg::OP_DIV_TJ_WAIT: begin
        if (div_done) tj2_q <= (div_quo == 24'd0) ? 24'd1 : div_quo;
      end
      sps_pkg::OP_L1_INIT: begin
        sa_q   <= '0;
        sv_q   <= $signed({1'b0, vel_q});
        dist_q <= '0;
        ent_q  <= '0;
        term_q <= $signed({1'b0, cfg_i.max_accel});
        t_q    <= '0;
        brk_q  <= 1'b0;
        run_q  <= 1'b0;
      end
      sps_pkg::OP_L1_STEP: begin
        if (!brk_q) begin
          sa_q <= sa1[24:0];
          if (sv1 <= 26'sd0) begin
            sv_q  <= '0;
            brk_q <= 1'b1;
          end else begin
            sv_q   <= sv1[24:0];
            dist_q <= sat_add(dist_q, {23'b0, sv1[24:0]});
          end
        end
        ent_q  <= ent_q + {{23{term_q[24]}}, term_q};
        term_q <= term_q - $signed({1'b0, cfg_i.jerk_step});
        run_q  <= (t_q == tj2_q - 24'd1);
        t_q    <= t_q + 24'd1;
      end
      sps_pkg::OP_DIV_TD_WAIT: begin
        if (div_done) td_q <= div_quo;
      end
      sps_pkg::OP_DIV_M_WAIT: begin
        if (div_done) m_q <= m_sel;
      end
      sps_pkg::OP_MUL_P1: p1_q <= 24'(cfg_i.max_accel * m_q);
      sps_pkg::OP_MUL_P2: p2_q <= p1_q * {1'b0, m_q + 24'd1};
      sps_pkg::OP_MUL_P3: p3_q <= m_q * sv_q[23:0];
      sps_pkg::OP_MID_SUM: begin
        dist_q <= sat_add(dist_q, mid_add);
        sv_q   <= (m_q < td_q) ? 25'sd0 : $signed({1'b0, sv_q[23:0] - p1_q});
      end
      sps_pkg::OP_L2_INIT: begin
        t_q    <= '0;
        run_q  <= 1'b0;
        tail_q <= 1'b0;
      end
      sps_pkg::OP_L2_STEP: begin
        sa_q <= sa2[24:0];
        t_q  <= t_q + 24'd1;
        if (sv2 <= 26'sd0) begin
          sv_q  <= '0;
          run_q <= 1'b1;
        end else begin
          sv_q   <= sv2[24:0];
          dist_q <= sat_add(dist_q, {23'b0, sv2[24:0]});
          if (sa2 == 26'sd0) begin
            tailk_q <= tj2_q - 24'd1 - t_q;
            tail_q  <= 1'b1;
            run_q   <= 1'b1;
          end else begin
            run_q <= (t_q == tj2_q - 24'd1);
          end
        end
      end
      sps_pkg::OP_TAIL_MUL: p3_q   <= tailk_q * sv_q[23:0];
      sps_pkg::OP_TAIL_ADD: dist_q <= sat_add(dist_q, p3_q);
      default:              brk_q  <= brk_q;
    endcase
  end

  always_comb begin
    status_o.seg_done     = (seg_q == sps_pkg::SEG_DONE);
    status_o.stop_skip    = (seg_q == sps_pkg::SEG_DONE) || (seg_q >= sps_pkg::SEG_DEC_JERK_UP);
    status_o.stop_trivial = (vel_q == 24'd0) || (cfg_i.max_accel == 24'd0) ||
                            (cfg_i.jerk_step == 24'd0);
    status_o.div_done     = div_done;
    status_o.div_quo_zero = (div_quo == 24'd0);
    status_o.run_done     = run_q;
    status_o.tail         = tail_q;
    result_o.position     = pos_q;
    result_o.speed        = vel_q;
    result_o.segment      = seg_q;
    result_o.done_res     = (seg_q == sps_pkg::SEG_DONE);
  end

endmodule

`default_nettype wire

/* hdl/sps_ctrl.sv */
// Controller of the S-curve profile step engine: sequences the datapath
// through tick, start and stop operations. Depends on sps_pkg.
`default_nettype none

module sps_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  input  wire logic [1:0]          action_i,
  input  wire logic                out_free_i,
  input  wire sps_pkg::dp_status_t status_i,
  output sps_pkg::cmd_t            cmd_o,
  output logic                     in_stall_o
);

  sps_pkg::state_e state_q, state_d;
  logic accept;

  assign accept     = in_valid_i && (state_q == sps_pkg::S_IDLE);
  assign in_stall_o = (state_q != sps_pkg::S_IDLE);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sps_pkg::S_IDLE: begin
        if (accept) begin
          unique case (action_i)
            sps_pkg::ACT_TICK:  state_d = status_i.seg_done ? sps_pkg::S_OUT
                                                            : sps_pkg::S_TICK_ACC;
            sps_pkg::ACT_START: state_d = sps_pkg::S_START;
            sps_pkg::ACT_STOP:  state_d = sps_pkg::S_STOP_CHK;
            default:            state_d = sps_pkg::S_OUT;
          endcase
        end
      end
      sps_pkg::S_TICK_ACC:  state_d = sps_pkg::S_TICK_VEL;
      sps_pkg::S_TICK_VEL:  state_d = sps_pkg::S_TICK_POS;
      sps_pkg::S_TICK_POS:  state_d = sps_pkg::S_TICK_SNAP;
      sps_pkg::S_TICK_SNAP: state_d = sps_pkg::S_OUT;
      sps_pkg::S_START:     state_d = sps_pkg::S_OUT;
      sps_pkg::S_STOP_CHK: begin
        if (status_i.stop_skip || status_i.stop_trivial) state_d = sps_pkg::S_OUT;
        else                                             state_d = sps_pkg::S_DTJ_GO;
      end
      sps_pkg::S_DTJ_GO:   state_d = sps_pkg::S_DTJ_WAIT;
      sps_pkg::S_DTJ_WAIT: if (status_i.div_done) state_d = sps_pkg::S_L1_INIT;
      sps_pkg::S_L1_INIT:  state_d = sps_pkg::S_L1;
      sps_pkg::S_L1:       if (status_i.run_done) state_d = sps_pkg::S_DTD_GO;
      sps_pkg::S_DTD_GO:   state_d = sps_pkg::S_DTD_WAIT;
      sps_pkg::S_DTD_WAIT: begin
        if (status_i.div_done) begin
          state_d = status_i.div_quo_zero ? sps_pkg::S_L2_INIT : sps_pkg::S_DM_GO;
        end
      end
      sps_pkg::S_DM_GO:    state_d = sps_pkg::S_DM_WAIT;
      sps_pkg::S_DM_WAIT:  if (status_i.div_done) state_d = sps_pkg::S_MUL1;
      sps_pkg::S_MUL1:     state_d = sps_pkg::S_MUL2;
      sps_pkg::S_MUL2:     state_d = sps_pkg::S_MUL3;
      sps_pkg::S_MUL3:     state_d = sps_pkg::S_MID;
      sps_pkg::S_MID:      state_d = sps_pkg::S_L2_INIT;
      sps_pkg::S_L2_INIT:  state_d = sps_pkg::S_L2;
      sps_pkg::S_L2: begin
        if (status_i.run_done) begin
          state_d = status_i.tail ? sps_pkg::S_TAIL_MUL : sps_pkg::S_STOP_END;
        end
      end
      sps_pkg::S_TAIL_MUL: state_d = sps_pkg::S_TAIL_ADD;
      sps_pkg::S_TAIL_ADD: state_d = sps_pkg::S_STOP_END;
      sps_pkg::S_STOP_END: state_d = sps_pkg::S_OUT;
      sps_pkg::S_OUT:      if (out_free_i) state_d = sps_pkg::S_IDLE;
      default:             state_d = sps_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.op       = sps_pkg::OP_NONE;
    cmd_o.load_out = 1'b0;
    unique case (state_q)
      sps_pkg::S_IDLE:      if (accept) cmd_o.op = sps_pkg::OP_LATCH;
      sps_pkg::S_TICK_ACC:  cmd_o.op = sps_pkg::OP_TICK_ACC;
      sps_pkg::S_TICK_VEL:  cmd_o.op = sps_pkg::OP_TICK_VEL;
      sps_pkg::S_TICK_POS:  cmd_o.op = sps_pkg::OP_TICK_POS;
      sps_pkg::S_TICK_SNAP: cmd_o.op = sps_pkg::OP_TICK_SNAP;
      sps_pkg::S_START:     cmd_o.op = sps_pkg::OP_START;
      sps_pkg::S_STOP_CHK: begin
        if (!status_i.stop_skip && status_i.stop_trivial) cmd_o.op = sps_pkg::OP_STOP_ZERO;
      end
      sps_pkg::S_DTJ_GO:    cmd_o.op = sps_pkg::OP_DIV_TJ_GO;
      sps_pkg::S_DTJ_WAIT:  cmd_o.op = sps_pkg::OP_DIV_TJ_WAIT;
      sps_pkg::S_L1_INIT:   cmd_o.op = sps_pkg::OP_L1_INIT;
      sps_pkg::S_L1:        if (!status_i.run_done) cmd_o.op = sps_pkg::OP_L1_STEP;
      sps_pkg::S_DTD_GO:    cmd_o.op = sps_pkg::OP_DIV_TD_GO;
      sps_pkg::S_DTD_WAIT:  cmd_o.op = sps_pkg::OP_DIV_TD_WAIT;
      sps_pkg::S_DM_GO:     cmd_o.op = sps_pkg::OP_DIV_M_GO;
      sps_pkg::S_DM_WAIT:   cmd_o.op = sps_pkg::OP_DIV_M_WAIT;
      sps_pkg::S_MUL1:      cmd_o.op = sps_pkg::OP_MUL_P1;
      sps_pkg::S_MUL2:      cmd_o.op = sps_pkg::OP_MUL_P2;
      sps_pkg::S_MUL3:      cmd_o.op = sps_pkg::OP_MUL_P3;
      sps_pkg::S_MID:       cmd_o.op = sps_pkg::OP_MID_SUM;
      sps_pkg::S_L2_INIT:   cmd_o.op = sps_pkg::OP_L2_INIT;
      sps_pkg::S_L2:        if (!status_i.run_done) cmd_o.op = sps_pkg::OP_L2_STEP;
      sps_pkg::S_TAIL_MUL:  cmd_o.op = sps_pkg::OP_TAIL_MUL;
      sps_pkg::S_TAIL_ADD:  cmd_o.op = sps_pkg::OP_TAIL_ADD;
      sps_pkg::S_STOP_END:  cmd_o.op = sps_pkg::OP_STOP_END;
      sps_pkg::S_OUT:       cmd_o.load_out = out_free_i;
      default:              cmd_o.op = sps_pkg::OP_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= sps_pkg::S_IDLE;
    else         state_q <= state_d;
  end

endmodule

`default_nettype wire

/* sim/testbench.sv */
// Self-checking testbench for scurve_profile_step_engine: a queue-fed driver,
// a clocked monitor and an in-line predictor of the S-curve profile.
// Depends on sps_pkg and the engine RTL only.
`timescale 1ns / 1ps

module testbench;

  // Action code 3 is not defined; the engine must leave its state alone.
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam logic [23:0] MASK24 = 24'hFF_FFFF;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  sps_pkg::in_t in_item_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  sps_pkg::out_t out_item_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [2:0] cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  scurve_profile_step_engine uut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_item_i,
    .out_valid_o, .out_stall_i, .out_item_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  // Items waiting to be offered, and results the predictor has produced.
  sps_pkg::in_t pending_items[$];
  sps_pkg::out_t expected_results[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatches = 0;
  int results_seen = 0;
  int stops_sent = 0;
  int starts_sent = 0;

  // Predictor copy of the configuration and the motion state.
  logic [23:0] c_max_speed = 24'd1, c_max_accel = 24'd1, c_jerk = 24'd1;
  logic [23:0] c_jerk_ticks = 24'd1, c_const_ticks = 24'd0;
  logic c_cruise = 1'b0;
  logic [30:0] c_brake = '0;
  logic [31:0] c_goal = '0;

  logic [31:0] m_pos = '0, m_target = '0, m_stop_dist = '0;
  logic [23:0] m_vel = '0, m_elapsed = '0, m_dec_jerk = '0, m_dec_const = '0;
  longint m_acc = 0;
  logic [2:0] m_seg = sps_pkg::SEG_DONE;
  logic m_neg = 1'b0;

  function automatic longint wrap_signed(logic [31:0] u);
    return {{32{u[31]}}, u};
  endfunction

  task automatic apply_register(logic [2:0] idx, logic [31:0] val);
    case (sps_pkg::cfg_idx_e'(idx))
      sps_pkg::CFG_MAX_SPEED:   c_max_speed = val[23:0];
      sps_pkg::CFG_MAX_ACCEL:   c_max_accel = val[23:0];
      sps_pkg::CFG_JERK_STEP:   c_jerk = val[23:0];
      sps_pkg::CFG_JERK_TICKS:  c_jerk_ticks = val[23:0];
      sps_pkg::CFG_CONST_TICKS: c_const_ticks = val[23:0];
      sps_pkg::CFG_CRUISE_EN:   c_cruise = val[0];
      sps_pkg::CFG_BRAKE_DIST:  c_brake = val[30:0];
      default:                  c_goal = val;
    endcase
  endtask

  task automatic start_move(logic [31:0] start);
    longint diff;
    diff = wrap_signed(c_goal - start);
    m_vel = '0;
    m_acc = 0;
    m_elapsed = '0;
    m_target = c_goal;
    if (diff == 0) begin
      // Zero travel finishes at once on the goal.
      m_pos = c_goal;
      m_seg = sps_pkg::SEG_DONE;
      m_neg = 1'b0;
      m_stop_dist = '0;
      m_dec_jerk = '0;
      m_dec_const = '0;
    end else begin
      m_neg = diff < 0;
      m_pos = start;
      m_seg = sps_pkg::SEG_JERK_UP;
      m_stop_dist = {1'b0, c_brake};
      m_dec_jerk = c_jerk_ticks;
      m_dec_const = c_const_ticks;
    end
  endtask

  // Smooth stop: simulate the clamped deceleration to find its length.
  task automatic smooth_stop();
    longint v, ma, j, sv, sa, dsum, tj2, td, entry, budget, t, m;
    v = m_vel;
    ma = c_max_accel;
    j = c_jerk;
    sa = 0;
    dsum = 0;
    if (m_seg == sps_pkg::SEG_DONE || m_seg >= sps_pkg::SEG_DEC_JERK_UP) return;
    if (v <= 0 || ma <= 0 || j <= 0) begin
      m_seg = sps_pkg::SEG_DONE;
      m_acc = 0;
      m_vel = '0;
      return;
    end
    tj2 = ma / j;
    if (tj2 < 1) tj2 = 1;
    sv = v;
    for (t = 0; t < tj2; t++) begin
      sa -= j;
      if (sa < -ma) sa = -ma;
      sv += sa;
      if (sv <= 0) begin
        sv = 0;
        break;
      end
      dsum += sv;
    end
    entry = ma * tj2 - (j * tj2) * (tj2 - 1) / 2;
    budget = sv - entry;
    if (budget < 0) budget = 0;
    td = budget / ma;
    if (td > 0) begin
      if (sv <= 0) begin
        sv = 0;
      end else begin
        m = (sv - 1) / ma;
        if (m > td) m = td;
        dsum += m * sv - ma * m * (m + 1) / 2;
        if (m < td) sv = 0;
        else sv -= m * ma;
      end
    end
    for (t = 0; t < tj2; t++) begin
      sa += j;
      if (sa > 0) sa = 0;
      sv += sa;
      if (sv <= 0) begin
        sv = 0;
        break;
      end
      dsum += sv;
      if (sa == 0) begin
        dsum += (tj2 - 1 - t) * sv;
        break;
      end
    end
    if (dsum > 64'h7FFF_FFFF) dsum = 64'h7FFF_FFFF;
    m_stop_dist = dsum[31:0];
    m_target = m_neg ? m_pos - dsum[31:0] : m_pos + dsum[31:0];
    m_dec_jerk = tj2[23:0];
    m_dec_const = td[23:0];
    m_seg = sps_pkg::SEG_DEC_JERK_UP;
    m_elapsed = '0;
    m_acc = 0;
  endtask

  task automatic profile_tick();
    longint acc, vel, jk, mxa, mxv, rem, el;
    acc = m_acc;
    vel = m_vel;
    jk = c_jerk;
    mxa = c_max_accel;
    mxv = c_max_speed;
    if (m_seg == sps_pkg::SEG_DONE) return;
    if (m_elapsed != MASK24) m_elapsed++;
    el = m_elapsed;
    case (m_seg)
      sps_pkg::SEG_JERK_UP: begin
        acc += jk;
        if (acc > mxa) acc = mxa;
        vel += acc;
        if (vel > mxv) vel = mxv;
        if (el >= c_jerk_ticks) begin
          if (c_const_ticks > 0) m_seg = sps_pkg::SEG_CONST_ACC;
          else if (vel >= mxv) m_seg = sps_pkg::SEG_CRUISE;
          else m_seg = sps_pkg::SEG_JERK_DOWN;
          m_elapsed = '0;
        end
      end
      sps_pkg::SEG_CONST_ACC: begin
        vel += mxa;
        if (vel > mxv) vel = mxv;
        if (el >= c_const_ticks) begin
          m_seg = sps_pkg::SEG_JERK_DOWN;
          m_elapsed = '0;
        end
      end
      sps_pkg::SEG_JERK_DOWN: begin
        acc -= jk;
        if (acc < 0) acc = 0;
        vel += acc;
        if (vel > mxv) vel = mxv;
        if (el >= c_jerk_ticks || acc <= 0) begin
          acc = 0;
          m_seg = c_cruise ? sps_pkg::SEG_CRUISE : sps_pkg::SEG_DEC_JERK_UP;
          m_elapsed = '0;
        end
      end
      sps_pkg::SEG_CRUISE: begin
        acc = 0;
        rem = m_neg ? wrap_signed(m_pos - m_target) : wrap_signed(m_target - m_pos);
        if (rem - vel <= longint'(m_stop_dist)) begin
          m_seg = sps_pkg::SEG_DEC_JERK_UP;
          m_elapsed = '0;
        end
      end
      sps_pkg::SEG_DEC_JERK_UP: begin
        acc -= jk;
        if (acc < -mxa) acc = -mxa;
        vel += acc;
        if (vel < 0) vel = 0;
        if (el >= m_dec_jerk) begin
          m_seg = m_dec_const > 0 ? sps_pkg::SEG_DEC_CONST : sps_pkg::SEG_DEC_JERK_DOWN;
          m_elapsed = '0;
        end
      end
      sps_pkg::SEG_DEC_CONST: begin
        vel -= mxa;
        if (vel < 0) vel = 0;
        if (el >= m_dec_const) begin
          m_seg = sps_pkg::SEG_DEC_JERK_DOWN;
          m_elapsed = '0;
        end
      end
      default: begin
        acc += jk;
        if (acc > 0) acc = 0;
        vel += acc;
        if (vel < 0) vel = 0;
        if (el >= m_dec_jerk || vel <= jk) begin
          vel = 0;
          acc = 0;
          m_seg = sps_pkg::SEG_DONE;
          m_elapsed = '0;
        end
      end
    endcase
    if (vel < 0) vel = 0;
    if (vel > MASK24) vel = MASK24;
    m_vel = vel[23:0];
    m_acc = acc;
    m_pos = m_neg ? m_pos - {8'd0, m_vel} : m_pos + {8'd0, m_vel};
    // Near-target snap once the speed has dropped to the stop speed.
    rem = wrap_signed(m_target - m_pos);
    if (rem < 0) rem = -rem;
    if (m_vel <= sps_pkg::StopSpeed && rem <= 2 && m_seg != sps_pkg::SEG_DONE) begin
      m_pos = m_target;
      m_vel = '0;
      m_acc = 0;
      m_seg = sps_pkg::SEG_DONE;
    end
  endtask

  task automatic predict_profile(sps_pkg::in_t it);
    sps_pkg::out_t r;
    case (it.action)
      sps_pkg::ACT_TICK:  profile_tick();
      sps_pkg::ACT_START: start_move(it.start_position);
      sps_pkg::ACT_STOP:  smooth_stop();
      default: ;
    endcase
    r.position = m_pos;
    r.speed = m_vel;
    r.segment = m_seg;
    r.done_res = m_seg == sps_pkg::SEG_DONE;
    expected_results.push_back(r);
  endtask

  // Driver: offers the head of the pending queue, idling at random.
  always @(posedge clk_i) begin
    logic taken;
    logic next_valid;
    if (rst_ni) begin
      taken = in_valid_i && !in_stall_o;
      next_valid = in_valid_i && !taken;
      if (taken) begin
        predict_profile(in_item_i);
        void'(pending_items.pop_front());
      end
      if (!next_valid && pending_items.size() > 0 &&
          $urandom_range(99) >= send_idle_pct) begin
        next_valid = 1'b1;
        in_item_i <= pending_items[0];
      end
      in_valid_i <= next_valid;
    end
  end

  // Monitor: checks every accepted result against the oldest expectation.
  always @(posedge clk_i) begin
    sps_pkg::out_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result item %p", out_item_o);
        end else begin
          want = expected_results.pop_front();
          if (out_item_o.position !== want.position || out_item_o.speed !== want.speed ||
              out_item_o.segment !== want.segment ||
              out_item_o.done_res !== want.done_res) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result %0d: expected pos %0d spd %0d seg %0d done %0d, got %0d %0d %0d %0d",
                       results_seen, want.position, want.speed, want.segment, want.done_res,
                       out_item_o.position, out_item_o.speed, out_item_o.segment,
                       out_item_o.done_res);
          end
        end
      end
      out_stall_i <= $urandom_range(99) < recv_stall_pct;
    end
  end

  function automatic sps_pkg::in_t make_item(logic [1:0] act, logic [31:0] start);
    sps_pkg::in_t it;
    it.action = act;
    it.start_position = start;
    return it;
  endfunction

  // One move: a start near (or far from) the goal, a run of ticks, and now and
  // then a smooth stop or a stray action code.
  task automatic queue_move();
    logic [31:0] start;
    int n;
    case ($urandom_range(9))
      0: start = c_goal;
      1: start = $urandom;
      default: start = c_goal + ($urandom_range(1) ? -$urandom_range(3000)
                                                     : $urandom_range(3000));
    endcase
    pending_items.push_back(make_item(sps_pkg::ACT_START, start));
    starts_sent++;
    n = $urandom_range(60, 5);
    for (int k = 0; k < n; k++) begin
      case ($urandom_range(39))
        0, 1: begin
          pending_items.push_back(make_item(sps_pkg::ACT_STOP, $urandom));
          stops_sent++;
        end
        2: pending_items.push_back(make_item(ACT_UNUSED, $urandom));
        default: pending_items.push_back(make_item(sps_pkg::ACT_TICK, $urandom));
      endcase
    end
  endtask

  // Writes all eight registers back to back; only called while idle.
  task automatic load_registers(logic [31:0] vals[8]);
    for (int i = 0; i < 8; i++) begin
      cfg_index_i <= i[2:0];
      cfg_data_i <= vals[i];
      cfg_valid_i <= 1'b1;
      do @(posedge clk_i); while (!cfg_ready_o);
      apply_register(i[2:0], vals[i]);
    end
    cfg_valid_i <= 1'b0;
  endtask

  task automatic wait_idle();
    while (pending_items.size() > 0 || expected_results.size() > 0 || in_valid_i)
      @(posedge clk_i);
  endtask

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("scurve_profile_step_engine: mismatch");
    $finish;
  end

  initial begin
    logic [31:0] regs[8];
    logic [23:0] jk;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int phase = 0; phase < 12; phase++) begin
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
        default: begin send_idle_pct = 19; recv_stall_pct = 19; end
      endcase
      case (phase)
        0: regs = '{32'd20, 32'd4, 32'd1, 32'd4, 32'd3, 32'd1, 32'd200, $urandom};
        // Upper extremes of every register.
        1: regs = '{32'hFF_FFFF, 32'hFF_FFFF, 32'hFF_FFFF, 32'hFF_FFFF, 32'hFF_FFFF,
                    32'd1, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
        // Lower extremes.
        2: regs = '{32'd1, 32'd1, 32'd1, 32'd1, 32'd0, 32'd0, 32'd0, 32'h8000_0000};
        3: regs = '{32'd500, 32'd60, 32'd2, 32'd30, 32'd5, 32'd1, $urandom_range(20000),
                    32'hFFFF_FFFE};
        4: regs = '{32'hFF_FFFF, 32'h80_0000, 32'h10_0000, 32'd3, 32'd0, 32'd1,
                    32'h4000_0000, $urandom};
        default: begin
          jk = 24'($urandom_range(5000, 1));
          regs = '{$urandom_range(3000, 1), jk * $urandom_range(40, 1), {8'd0, jk},
                   $urandom_range(40, 1), $urandom_range(8), $urandom_range(1),
                   $urandom_range(1) ? $urandom_range(4000) : $urandom_range(32'h3FFF_FFFF),
                   $urandom};
        end
      endcase
      load_registers(regs);
      if (phase == 0) begin
        // Directed opening: idle tick, stop while done, stray code, zero travel,
        // stop at zero speed, stop mid-move, stop while decelerating, restart.
        pending_items.push_back(make_item(sps_pkg::ACT_TICK, 32'hFFFF_FFFF));
        pending_items.push_back(make_item(sps_pkg::ACT_STOP, 32'h0));
        pending_items.push_back(make_item(ACT_UNUSED, 32'h8000_0000));
        pending_items.push_back(make_item(sps_pkg::ACT_START, c_goal));
        pending_items.push_back(make_item(sps_pkg::ACT_START, c_goal - 32'd1000));
        pending_items.push_back(make_item(sps_pkg::ACT_STOP, 32'h7FFF_FFFF));
        pending_items.push_back(make_item(sps_pkg::ACT_START, c_goal + 32'd1000));
        for (int k = 0; k < 6; k++)
          pending_items.push_back(make_item(sps_pkg::ACT_TICK, $urandom));
        pending_items.push_back(make_item(sps_pkg::ACT_STOP, $urandom));
        pending_items.push_back(make_item(sps_pkg::ACT_TICK, $urandom));
        pending_items.push_back(make_item(sps_pkg::ACT_STOP, $urandom));
        for (int k = 0; k < 6; k++)
          pending_items.push_back(make_item(sps_pkg::ACT_TICK, $urandom));
        pending_items.push_back(make_item(sps_pkg::ACT_START, c_goal + 32'd1));
        pending_items.push_back(make_item(sps_pkg::ACT_TICK, $urandom));
        stops_sent += 4;
        starts_sent += 4;
      end
      for (int mv = 0; mv < 4; mv++) queue_move();
      wait_idle();
      repeat (20) @(posedge clk_i);
    end
    repeat (200) @(posedge clk_i);
    $display("Ran 12 register settings with %0d starts and %0d smooth stops, %0d results checked.",
             starts_sent, stops_sent, results_seen);
    $display("Idling covered none, sender only, receiver only and both sides.");
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("scurve_profile_step_engine: match");
    end else begin
      $display("scurve_profile_step_engine: mismatch");
    end
    $finish;
  end

endmodule

/* filelist.f */
hdl/sps_pkg.sv
hdl/sps_div.sv
hdl/sps_dp.sv
hdl/sps_ctrl.sv
hdl/scurve_profile_step_engine.sv
sim/testbench.sv
